### design/box_area_downscaler_defines.svh
// Assertion macros used by the checker file of the box area downscaler.
`ifndef BOX_AREA_DOWNSCALER_DEFINES_SVH
`define BOX_AREA_DOWNSCALER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BXDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bxds assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BXDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bxds assertion failed");

`endif

### design/bxds_pkg.sv
// Shared constants, types and helpers of the box area downscaler.
package bxds_pkg;

    localparam int MAX_SIDE = 4096;
    localparam int SIDE_W   = $clog2(MAX_SIDE) + 1;
    localparam int POS_W    = $clog2(MAX_SIDE);
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 2 * POS_W + PIX_W;
    localparam int CNT_W    = 2 * SIDE_W;
    localparam int NCH      = 4;
    localparam int REG_W    = 13;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_DST_W = 2'd2;
    localparam logic [1:0] REG_DST_H = 2'd3;

    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic init;
        logic setup_step;
        logic setup_done;
        logic accept;
        logic rd;
        logic add;
        logic div_step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_stat;

    // Zero acts as one, anything above MAX_SIDE saturates.
    function automatic logic [SIDE_W-1:0] eff_side(input logic [REG_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (SIDE_W'(v) > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

endpackage

### design/bxds_div.sv
// Four-channel restoring divider, one quotient bit per step, 8-bit quotients.
module bxds_div (
    input  logic                 i_clk,
    input  logic                 i_start,
    input  logic                 i_step,
    input  bxds_pkg::t_sum       i_sum [bxds_pkg::NCH],
    input  logic [bxds_pkg::CNT_W-1:0] i_cnt,
    output bxds_pkg::t_pix       o_quo [bxds_pkg::NCH]
);
    import bxds_pkg::*;

    t_sum             r_rem [NCH];
    t_pix             r_quo [NCH];
    logic [SUM_W:0]   r_den;

    // quotient never exceeds 255 since sum <= 255 * count
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= (SUM_W+1)'(i_cnt) << (PIX_W - 1);
            for (int c = 0; c < NCH; c++) begin
                r_rem[c] <= i_sum[c];
                r_quo[c] <= '0;
            end
        end else if (i_step) begin
            r_den <= r_den >> 1;
            for (int c = 0; c < NCH; c++) begin
                if ({1'b0, r_rem[c]} >= r_den) begin
                    r_rem[c] <= r_rem[c] - r_den[SUM_W-1:0];
                    r_quo[c] <= {r_quo[c][PIX_W-2:0], 1'b1};
                end else begin
                    r_quo[c] <= {r_quo[c][PIX_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo;

endmodule

### design/bxds_ctrl.sv
// Controller state machine of the box area downscaler.
module bxds_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr,
    input  logic            i_in_valid,
    input  bxds_pkg::t_stat i_stat,
    output bxds_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);
    import bxds_pkg::*;

    localparam int STEP_W = $clog2(SIDE_W + 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_IDLE  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_LOAD  = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_cnt      = '0;
                n_state    = ST_SETUP;
            end
            ST_SETUP: begin
                o_cmd.setup_step = 1'b1;
                if (r_cnt == STEP_W'(SIDE_W - 1)) begin
                    n_state = ST_START;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_START: begin
                o_cmd.setup_done = 1'b1;
                n_state          = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_cnt     = '0;
                n_state   = i_stat.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == STEP_W'(PIX_W - 1)) begin
                    n_state = ST_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
        // a register write restarts the frame
        if (i_cfg_wr) begin
            n_state = ST_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### design/bxds_dp.sv
// Datapath: boundary tracking, column sum memory, divider and output register.
module bxds_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bxds_pkg::t_cmd              i_cmd,
    input  logic [bxds_pkg::REG_W-1:0]  i_src_w,
    input  logic [bxds_pkg::REG_W-1:0]  i_src_h,
    input  logic [bxds_pkg::REG_W-1:0]  i_dst_w,
    input  logic [bxds_pkg::REG_W-1:0]  i_dst_h,
    input  logic [bxds_pkg::PIX_W-1:0]  i_red,
    input  logic [bxds_pkg::PIX_W-1:0]  i_green,
    input  logic [bxds_pkg::PIX_W-1:0]  i_blue,
    input  logic [bxds_pkg::PIX_W-1:0]  i_alpha,
    input  logic                        i_out_stall,
    output bxds_pkg::t_stat             o_stat,
    output logic                        o_out_valid,
    output logic [bxds_pkg::POS_W-1:0]  o_dest_col,
    output logic [bxds_pkg::POS_W-1:0]  o_dest_row,
    output logic [bxds_pkg::PIX_W-1:0]  o_red,
    output logic [bxds_pkg::PIX_W-1:0]  o_green,
    output logic [bxds_pkg::PIX_W-1:0]  o_blue,
    output logic [bxds_pkg::PIX_W-1:0]  o_alpha,
    output logic                        o_frame_done
);
    import bxds_pkg::*;

    // effective sizes
    logic [SIDE_W-1:0] w_sw, w_sh, w_dw, w_dh, w_dw_raw, w_dh_raw;

    always_comb begin
        w_sw     = eff_side(i_src_w);
        w_sh     = eff_side(i_src_h);
        w_dw_raw = eff_side(i_dst_w);
        w_dh_raw = eff_side(i_dst_h);
        w_dw     = (w_dw_raw > w_sw) ? w_sw : w_dw_raw;
        w_dh     = (w_dh_raw > w_sh) ? w_sh : w_dh_raw;
    end

    // step sizes s/d: quotient and remainder, one bit per setup step
    logic [SIDE_W-1:0] r_qw, r_rw, r_qh, r_rh;
    logic [SIDE_W:0]   w_tw, w_th;
    logic              w_gew, w_geh;

    always_comb begin
        w_tw  = {r_rw, r_qw[SIDE_W-1]};
        w_th  = {r_rh, r_qh[SIDE_W-1]};
        w_gew = (w_tw >= {1'b0, w_dw});
        w_geh = (w_th >= {1'b0, w_dh});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_qw <= w_sw;
            r_rw <= '0;
            r_qh <= w_sh;
            r_rh <= '0;
        end else if (i_cmd.setup_step) begin
            r_qw <= {r_qw[SIDE_W-2:0], w_gew};
            r_qh <= {r_qh[SIDE_W-2:0], w_geh};
            r_rw <= w_gew ? SIDE_W'(w_tw - {1'b0, w_dw}) : w_tw[SIDE_W-1:0];
            r_rh <= w_geh ? SIDE_W'(w_th - {1'b0, w_dh}) : w_th[SIDE_W-1:0];
        end
    end

    // frame position and block bounds
    logic [SIDE_W-1:0] r_src_col, r_src_row, r_col_start, r_col_end, r_col_rem;
    logic [SIDE_W-1:0] r_row_start, r_row_end, r_row_rem;
    logic [POS_W-1:0]  r_dst_col, r_dst_row;

    logic [SIDE_W-1:0] w_src_col_p1, w_src_row_p1, w_dst_col_p1, w_dst_row_p1;
    logic [SIDE_W:0]   w_col_acc, w_row_acc;
    logic              w_col_cy, w_row_cy;
    logic [SIDE_W-1:0] w_col_rem_n, w_row_rem_n, w_col_end_n, w_row_end_n;
    logic              w_emit, w_fresh, w_done;

    always_comb begin
        w_src_col_p1 = r_src_col + 1'b1;
        w_src_row_p1 = r_src_row + 1'b1;
        w_dst_col_p1 = SIDE_W'(r_dst_col) + 1'b1;
        w_dst_row_p1 = SIDE_W'(r_dst_row) + 1'b1;
        // incremental boundary: floor((i+1)s/d) from floor(is/d)
        w_col_acc    = {1'b0, r_col_rem} + {1'b0, r_rw};
        w_row_acc    = {1'b0, r_row_rem} + {1'b0, r_rh};
        w_col_cy     = (w_col_acc >= {1'b0, w_dw});
        w_row_cy     = (w_row_acc >= {1'b0, w_dh});
        w_col_rem_n  = w_col_cy ? SIDE_W'(w_col_acc - {1'b0, w_dw}) : w_col_acc[SIDE_W-1:0];
        w_row_rem_n  = w_row_cy ? SIDE_W'(w_row_acc - {1'b0, w_dh}) : w_row_acc[SIDE_W-1:0];
        w_col_end_n  = r_col_end + r_qw + SIDE_W'(w_col_cy);
        w_row_end_n  = r_row_end + r_qh + SIDE_W'(w_row_cy);
        w_emit       = (w_src_col_p1 == r_col_end) && (w_src_row_p1 == r_row_end);
        // first pixel of a column block in the band's top row starts a new sum
        w_fresh      = (r_src_row == r_row_start) && (r_src_col == r_col_start);
        w_done       = (w_dst_col_p1 == w_dw) && (w_dst_row_p1 == w_dh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_dst_col   <= '0;
            r_dst_row   <= '0;
            r_col_start <= '0;
            r_col_end   <= '0;
            r_col_rem   <= '0;
            r_row_start <= '0;
            r_row_end   <= '0;
            r_row_rem   <= '0;
        end else if (i_cmd.setup_done) begin
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_dst_col   <= '0;
            r_dst_row   <= '0;
            r_col_start <= '0;
            r_col_end   <= r_qw;
            r_col_rem   <= r_rw;
            r_row_start <= '0;
            r_row_end   <= r_qh;
            r_row_rem   <= r_rh;
        end else if (i_cmd.add) begin
            if (w_src_col_p1 >= w_sw) begin
                r_src_col   <= '0;
                r_dst_col   <= '0;
                r_col_start <= '0;
                r_col_end   <= r_qw;
                r_col_rem   <= r_rw;
                if (w_src_row_p1 >= w_sh) begin
                    r_src_row   <= '0;
                    r_dst_row   <= '0;
                    r_row_start <= '0;
                    r_row_end   <= r_qh;
                    r_row_rem   <= r_rh;
                end else begin
                    r_src_row <= w_src_row_p1;
                    if (w_src_row_p1 >= r_row_end && w_dst_row_p1 < w_dh) begin
                        r_dst_row   <= w_dst_row_p1[POS_W-1:0];
                        r_row_start <= r_row_end;
                        r_row_end   <= w_row_end_n;
                        r_row_rem   <= w_row_rem_n;
                    end
                end
            end else begin
                r_src_col <= w_src_col_p1;
                if (w_src_col_p1 >= r_col_end && w_dst_col_p1 < w_dw) begin
                    r_dst_col   <= w_dst_col_p1[POS_W-1:0];
                    r_col_start <= r_col_end;
                    r_col_end   <= w_col_end_n;
                    r_col_rem   <= w_col_rem_n;
                end
            end
        end
    end

    // pixel latch and column sum memory (read-modify-write)
    t_pix                   r_pix [NCH];
    logic [NCH*SUM_W-1:0]   mem [MAX_SIDE];
    logic [NCH*SUM_W-1:0]   r_rd;
    logic [NCH*SUM_W-1:0]   w_new;
    t_sum                   w_sum [NCH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix[0] <= i_red;
            r_pix[1] <= i_green;
            r_pix[2] <= i_blue;
            r_pix[3] <= i_alpha;
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_sum[c] = (w_fresh ? '0 : r_rd[c*SUM_W +: SUM_W]) + SUM_W'(r_pix[c]);
            w_new[c*SUM_W +: SUM_W] = w_sum[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= mem[r_dst_col];
        end
        if (i_cmd.add) begin
            mem[r_dst_col] <= w_new;
        end
    end

    // block pixel count and divider
    logic [CNT_W-1:0] w_cnt;
    t_pix             w_quo [NCH];
    logic             w_div_start;

    always_comb begin
        w_cnt       = CNT_W'(r_col_end - r_col_start) * CNT_W'(r_row_end - r_row_start);
        w_div_start = i_cmd.add && w_emit;
    end

    bxds_div u_div (
        .i_clk   (i_clk),
        .i_start (w_div_start),
        .i_step  (i_cmd.div_step),
        .i_sum   (w_sum),
        .i_cnt   (w_cnt),
        .o_quo   (w_quo)
    );

    logic [POS_W-1:0] r_blk_col, r_blk_row;
    logic             r_blk_done;

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_blk_col  <= r_dst_col;
            r_blk_row  <= r_dst_row;
            r_blk_done <= w_done;
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_dest_col   <= r_blk_col;
            o_dest_row   <= r_blk_row;
            o_red        <= w_quo[0];
            o_green      <= w_quo[1];
            o_blue       <= w_quo[2];
            o_alpha      <= w_quo[3];
            o_frame_done <= r_blk_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.emit     = w_emit;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

### design/box_area_downscaler.sv
// Box area downscaler: streaming RGBA area-average reduction of one frame to a smaller size.
// Source pixels come in raster order over the input channel; each destination pixel is the
// truncated mean of its source block and leaves on the output channel once the block's
// bottom-right pixel is in, tagged with its column and row and a frame_done flag on the last
// one. Sizes are set through the APB registers (src_width 0x0, src_height 0x4, dst_width 0x8,
// dst_height 0xC); zero acts as 1, values above 4096 saturate, and a destination larger than
// the source is clamped to it. Any register write restarts the frame. After reset and after
// each register write the block works out the block step sizes with a one-bit-per-cycle
// divider, with stall high. A pixel then passes through accept, column sum memory read, and
// add and write back on the single memory port. A pixel that closes a block then also passes
// through the four-channel shift-subtract divider, one quotient bit per cycle, and the load
// of the output register. A finished result waits in that register while the next pixel is
// being taken in.
module box_area_downscaler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bxds_pkg::ADDR_W-1:0]    paddr,
    input  logic [bxds_pkg::DATA_W-1:0]    pwdata,
    output logic [bxds_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    // source pixels
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bxds_pkg::PIX_W-1:0]     i_in_red,
    input  logic [bxds_pkg::PIX_W-1:0]     i_in_green,
    input  logic [bxds_pkg::PIX_W-1:0]     i_in_blue,
    input  logic [bxds_pkg::PIX_W-1:0]     i_in_alpha,
    // destination pixels
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bxds_pkg::POS_W-1:0]     o_dest_col,
    output logic [bxds_pkg::POS_W-1:0]     o_dest_row,
    output logic [bxds_pkg::PIX_W-1:0]     o_out_red,
    output logic [bxds_pkg::PIX_W-1:0]     o_out_green,
    output logic [bxds_pkg::PIX_W-1:0]     o_out_blue,
    output logic [bxds_pkg::PIX_W-1:0]     o_out_alpha,
    output logic                           o_frame_done
);
    import bxds_pkg::*;

    // size registers
    logic [REG_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic             w_cfg_wr;
    logic [1:0]       w_idx;

    assign pready   = 1'b1;
    assign w_idx    = paddr[3:2];
    // write transfer completes in the access phase
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= REG_W'(MAX_SIDE);
            r_src_h <= REG_W'(MAX_SIDE);
            r_dst_w <= REG_W'(MAX_SIDE);
            r_dst_h <= REG_W'(MAX_SIDE);
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_SRC_W: r_src_w <= pwdata[REG_W-1:0];
                REG_SRC_H: r_src_h <= pwdata[REG_W-1:0];
                REG_DST_W: r_dst_w <= pwdata[REG_W-1:0];
                REG_DST_H: r_dst_h <= pwdata[REG_W-1:0];
                default:   r_src_w <= r_src_w;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SRC_W: prdata = DATA_W'(r_src_w);
            REG_SRC_H: prdata = DATA_W'(r_src_h);
            REG_DST_W: prdata = DATA_W'(r_dst_w);
            REG_DST_H: prdata = DATA_W'(r_dst_h);
            default:   prdata = '0;
        endcase
    end

    t_cmd  w_cmd;
    t_stat w_stat;

    bxds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (w_cfg_wr),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    bxds_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_src_w      (r_src_w),
        .i_src_h      (r_src_h),
        .i_dst_w      (r_dst_w),
        .i_dst_h      (r_dst_h),
        .i_red        (i_in_red),
        .i_green      (i_in_green),
        .i_blue       (i_in_blue),
        .i_alpha      (i_in_alpha),
        .i_out_stall  (i_out_stall),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_dest_col   (o_dest_col),
        .o_dest_row   (o_dest_row),
        .o_red        (o_out_red),
        .o_green      (o_out_green),
        .o_blue       (o_out_blue),
        .o_alpha      (o_out_alpha),
        .o_frame_done (o_frame_done)
    );

endmodule

### design/bxds_checker.sv
// Port-level checker of the box area downscaler and its bind.
`include "box_area_downscaler_defines.svh"

module bxds_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [bxds_pkg::POS_W-1:0]  o_dest_col,
    input logic [bxds_pkg::POS_W-1:0]  o_dest_row,
    input logic                        o_frame_done
);
    // stalled result holds
    `BXDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_dest_col) && $stable(o_dest_row) && $stable(o_frame_done))
    // one pixel at a time: stall right after a transfer
    `BXDS_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // register write restarts setup
    `BXDS_ASSERT_NEXT(a_cfg_busy, i_clk, i_rst_n, psel && penable && pwrite, o_in_stall)
    // results are loaded only while a pixel is in flight
    `BXDS_ASSERT_NOW(a_load_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))
endmodule

bind box_area_downscaler bxds_checker u_bxds_checker (.*);

### tb/testbench.sv
// Self-checking testbench of the box area downscaler: directed table, a wide block, then random frames.
`timescale 1ns / 1ps

module testbench;
    import bxds_pkg::*;

    // One destination pixel as it leaves the block.
    typedef struct {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             done;
    } t_dst_pix;

    // One row of the directed table: a register write or a source pixel.
    typedef struct {
        bit               is_cfg;
        logic [1:0]       idx;
        logic [31:0]      val;
        logic [PIX_W-1:0] red, green, blue, alpha;
        bit               typed;
        t_dst_pix         want;
    } t_step;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 30;   // setup pass plus one block divide, with margin
    localparam int WIDE_SIDE      = 256;
    localparam int RANDOM_ITEMS   = 1580;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel, penable, pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [PIX_W-1:0]        i_in_red, i_in_green, i_in_blue, i_in_alpha;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [POS_W-1:0]        o_dest_col, o_dest_row;
    logic [PIX_W-1:0]        o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic                    o_frame_done;

    box_area_downscaler dut (.*);

    // ------------------------------------------------------------------
    // Predictor state: register copies, column sums and frame position.
    // ------------------------------------------------------------------
    int unsigned     size_reg [4];
    longint unsigned col_sum_r [MAX_SIDE];
    longint unsigned col_sum_g [MAX_SIDE];
    longint unsigned col_sum_b [MAX_SIDE];
    longint unsigned col_sum_a [MAX_SIDE];
    int unsigned     src_x, src_y, dst_x, dst_y;
    int unsigned     x_start, x_end, y_start, y_end;

    t_dst_pix        pending_pix [$];   // destination pixels still owed by the block
    int              mismatches;
    int              idle_cycles;
    bit              quiet;             // no sender gaps and no new receiver stalls while set
    int              sent;

    // Transfer tag: the directed table types some expectations in by hand.
    bit              cur_typed;
    t_dst_pix        cur_want;

    function automatic int unsigned side_of(int unsigned v);
        int unsigned s;
        s = v & 32'h1FFF;
        if (s == 0) s = 1;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s;
    endfunction

    function automatic int unsigned cut(int unsigned i, int unsigned s, int unsigned d);
        longint unsigned p;
        p = longint'(i) * longint'(s);
        return int'(p / d);
    endfunction

    function automatic int unsigned eff_dst(int unsigned dreg, int unsigned sreg);
        int unsigned d, s;
        d = side_of(dreg);
        s = side_of(sreg);
        return (d > s) ? s : d;
    endfunction

    function void restart_frame();
        for (int i = 0; i < MAX_SIDE; i++) begin
            col_sum_r[i] = 0; col_sum_g[i] = 0; col_sum_b[i] = 0; col_sum_a[i] = 0;
        end
        src_x = 0; src_y = 0; dst_x = 0; dst_y = 0;
        x_start = 0;
        x_end = cut(1, side_of(size_reg[REG_SRC_W]),
                    eff_dst(size_reg[REG_DST_W], size_reg[REG_SRC_W]));
        y_start = 0;
        y_end = cut(1, side_of(size_reg[REG_SRC_H]),
                    eff_dst(size_reg[REG_DST_H], size_reg[REG_SRC_H]));
    endfunction

    // Accumulate one source pixel; returns 1 when it closes a block.
    function bit downscale_pixel(input logic [PIX_W-1:0] r, g, b, a, output t_dst_pix o);
        int unsigned     sw, sh, dw, dh, dx;
        longint unsigned cnt;
        bit              hit;
        sw = side_of(size_reg[REG_SRC_W]);
        sh = side_of(size_reg[REG_SRC_H]);
        dw = eff_dst(size_reg[REG_DST_W], size_reg[REG_SRC_W]);
        dh = eff_dst(size_reg[REG_DST_H], size_reg[REG_SRC_H]);
        dx = (dst_x >= MAX_SIDE) ? MAX_SIDE - 1 : dst_x;
        hit = 0;
        o = '{default: '0};
        col_sum_r[dx] += r; col_sum_g[dx] += g; col_sum_b[dx] += b; col_sum_a[dx] += a;
        if (src_x + 1 == x_end && src_y + 1 == y_end) begin
            cnt = longint'(x_end - x_start) * longint'(y_end - y_start);
            if (cnt == 0) cnt = 1;
            o.col   = dst_x[POS_W-1:0];
            o.row   = dst_y[POS_W-1:0];
            o.red   = PIX_W'(col_sum_r[dx] / cnt);
            o.green = PIX_W'(col_sum_g[dx] / cnt);
            o.blue  = PIX_W'(col_sum_b[dx] / cnt);
            o.alpha = PIX_W'(col_sum_a[dx] / cnt);
            o.done  = (dst_x + 1 == dw) && (dst_y + 1 == dh);
            col_sum_r[dx] = 0; col_sum_g[dx] = 0; col_sum_b[dx] = 0; col_sum_a[dx] = 0;
            hit = 1;
        end
        if (src_x + 1 >= x_end && dst_x + 1 < dw) begin
            dst_x++;
            x_start = x_end;
            x_end = cut(dst_x + 1, sw, dw);
        end
        src_x++;
        if (src_x >= sw) begin
            src_x = 0; dst_x = 0; x_start = 0;
            x_end = cut(1, sw, dw);
            src_y++;
            if (src_y >= sh) begin
                src_y = 0; dst_y = 0; y_start = 0;
                y_end = cut(1, sh, dh);
            end else if (src_y >= y_end && dst_y + 1 < dh) begin
                dst_y++;
                y_start = y_end;
                y_end = cut(dst_y + 1, sh, dh);
            end
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Clock and the single reset at the start.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted source transfer, checks every
    // accepted destination transfer, and keeps the watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dst_pix e, got;
        bit       hit, act;
        act = 0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                hit = downscale_pixel(i_in_red, i_in_green, i_in_blue, i_in_alpha, e);
                if (cur_typed) pending_pix.push_back(cur_want);
                else if (hit) pending_pix.push_back(e);
                act = 1;
            end
            if (psel && penable && pwrite && pready) act = 1;
            if (o_out_valid && !i_out_stall) begin
                act = 1;
                got = '{o_dest_col, o_dest_row, o_out_red, o_out_green, o_out_blue,
                        o_out_alpha, o_frame_done};
                if (pending_pix.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transfer col=%0d row=%0d",
                                 got.col, got.row);
                end else begin
                    e = pending_pix.pop_front();
                    if (got.col !== e.col || got.row !== e.row || got.red !== e.red ||
                        got.green !== e.green || got.blue !== e.blue ||
                        got.alpha !== e.alpha || got.done !== e.done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp col=%0d row=%0d rgba=%h %h %h %h fd=%b",
                                      " | got col=%0d row=%0d rgba=%h %h %h %h fd=%b"},
                                     e.col, e.row, e.red, e.green, e.blue, e.alpha, e.done,
                                     got.col, got.row, got.red, got.green, got.blue,
                                     got.alpha, got.done);
                    end
                end
            end
        end
        idle_cycles = act ? 0 : idle_cycles + 1;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: free stretches mostly, short stalls often and a
    // few long ones. Changes only at the falling edge.
    // ------------------------------------------------------------------
    initial begin
        int left, r;
        left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                r = $urandom_range(0, 99);
                if (quiet) begin
                    i_out_stall <= 1'b0; left = 16;
                end else if (r < 55) begin
                    i_out_stall <= 1'b0; left = $urandom_range(1, 20);
                end else if (r < 85) begin
                    i_out_stall <= 1'b1; left = $urandom_range(1, 3);
                end else if (r < 97) begin
                    i_out_stall <= 1'b1; left = $urandom_range(4, 12);
                end else begin
                    i_out_stall <= 1'b1; left = $urandom_range(20, 60);
                end
            end
            left--;
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, a,
                              input bit typed, input t_dst_pix want);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        i_in_alpha <= a;
        cur_typed  <= typed;
        cur_want   <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_random_pixel();
        send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                   0, '{default: '0});
    endtask

    // Block must be idle: every owed pixel out, then room for a pixel that
    // closed no block and for the block divide still in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_pix.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup phase, access phase, then idle; pready is tied high.
    task automatic size_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        size_reg[idx] = val & 32'h1FFF;
        restart_frame();
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_sizes(input int unsigned sw, sh, dw, dh);
        wait_idle();
        size_write(REG_SRC_W, sw);
        size_write(REG_SRC_H, sh);
        size_write(REG_DST_W, dw);
        size_write(REG_DST_H, dh);
    endtask

    // Random register value: small sizes mostly, extremes now and then.
    function automatic int unsigned pick_src();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82) return $urandom_range(1, 12);
        if (r < 92) return $urandom_range(13, 64);
        if (r < 95) return 0;
        if (r < 97) return MAX_SIDE;
        return $urandom_range(MAX_SIDE + 1, 8191) | ($urandom & 32'hFFFF_E000);
    endfunction

    function automatic int unsigned pick_dst(input int unsigned src);
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(1, side_of(src) + 2);
        if (r < 94) return 0;
        return 8191;
    endfunction

    // Directed table, built once.
    t_step plan [$];

    task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
        t_step s;
        s = '{default: '0};
        s.is_cfg = 1; s.idx = idx; s.val = val;
        plan.push_back(s);
    endtask

    task automatic add_pix(input logic [PIX_W-1:0] r, g, b, a);
        t_step s;
        s = '{default: '0};
        s.red = r; s.green = g; s.blue = b; s.alpha = a;
        plan.push_back(s);
    endtask

    task automatic add_pix_want(input logic [PIX_W-1:0] r, g, b, a,
                                input int c, w, input logic [PIX_W-1:0] er, eg, eb, ea,
                                input bit fd);
        t_step s;
        s = '{default: '0};
        s.red = r; s.green = g; s.blue = b; s.alpha = a;
        s.typed = 1;
        s.want = '{c[POS_W-1:0], w[POS_W-1:0], er, eg, eb, ea, fd};
        plan.push_back(s);
    endtask

    initial begin
        int unsigned sw, sh, dw, dh, n;
        int          target;
        bit          pressed;

        mismatches  = 0;
        idle_cycles = 0;
        sent        = 0;
        quiet       = 0;
        pressed     = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_in_valid = 0; i_in_red = '0; i_in_green = '0; i_in_blue = '0; i_in_alpha = '0;
        cur_typed = 0; cur_want = '{default: '0};
        for (int i = 0; i < 4; i++) size_reg[i] = MAX_SIDE;
        restart_frame();

        // Out of reset every size is 4096, so each pixel is its own block.
        add_pix_want(8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0);
        add_pix_want(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        add_pix_want(8'hAA, 8'h55, 8'h0F, 8'hF0, 2, 0, 8'hAA, 8'h55, 8'h0F, 8'hF0, 0);
        add_pix_want(8'h01, 8'h80, 8'h7F, 8'hFE, 3, 0, 8'h01, 8'h80, 8'h7F, 8'hFE, 0);
        // Zero width acts as one, oversize destination clamps: a 1x2 block.
        add_cfg(REG_SRC_W, 0);
        add_cfg(REG_SRC_H, 2);
        add_cfg(REG_DST_W, 8191);
        add_cfg(REG_DST_H, 1);
        add_pix(8'hFF, 8'hFE, 8'h01, 8'h00);
        add_pix_want(8'hFF, 8'hFF, 8'h00, 8'h00, 0, 0, 8'hFF, 8'hFE, 8'h00, 8'h00, 1);
        // Uneven column split 3 -> 2, upscale request on height clamps to 1.
        add_cfg(REG_SRC_W, 3);
        add_cfg(REG_SRC_H, 1);
        add_cfg(REG_DST_W, 2);
        add_cfg(REG_DST_H, 5);
        add_pix(8'h10, 8'h20, 8'h30, 8'h40);
        add_pix(8'hFF, 8'h00, 8'h81, 8'h7E);
        add_pix(8'hFE, 8'h01, 8'h80, 8'h7F);
        add_pix(8'h33, 8'hCC, 8'h99, 8'h66);   // next frame starts right after the wrap
        // Oversize source saturates to 4096; mid-row write restarts the frame.
        add_cfg(REG_SRC_W, 5000);
        add_pix(8'h12, 8'h34, 8'h56, 8'h78);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                wait_idle();
                size_write(plan[k].idx, plan[k].val);
            end else begin
                send_pixel(plan[k].red, plan[k].green, plan[k].blue, plan[k].alpha,
                           plan[k].typed, plan[k].want);
            end
        end
        cur_typed <= 1'b0;

        // Wide block: one 256x1 row averaged into a single pixel of full-scale sums.
        set_sizes(WIDE_SIDE, 1, 1, 1);
        quiet = 1;
        repeat (WIDE_SIDE) send_pixel(8'hFF, 8'hFF, 8'hFF, PIX_W'($urandom), 0,
                                      '{default: '0});
        quiet = 0;

        // Random frames: mostly whole frames at small sizes, some cut short.
        target = sent + RANDOM_ITEMS;
        while (sent < target) begin
            sw = pick_src(); sh = pick_src();
            dw = pick_dst(sw); dh = pick_dst(sh);
            set_sizes(sw, sh, dw, dh);
            n = side_of(sw) * side_of(sh) * $urandom_range(1, 3);
            if (n > 400 || $urandom_range(0, 99) < 15) n = $urandom_range(1, 200);
            quiet = ($urandom_range(0, 99) < 15);
            for (int i = 0; i < n; i++) begin
                if (sent >= target) break;
                // Once, hold the sender until the block has caught up.
                if (!pressed && i == n / 2 && sent > target - RANDOM_ITEMS + 200) begin
                    i_in_valid <= 1'b0;
                    @(negedge i_clk);
                    while (pending_pix.size() != 0) @(negedge i_clk);
                    pressed = 1;
                end
                send_random_pixel();
            end
            quiet = 0;
        end

        // Drain, then allow the block's latency to expose any stray transfer.
        i_in_valid <= 1'b0;
        while (pending_pix.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_pix.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial i_rst_n = 1'b0;

endmodule

### filelist.f
+incdir+design
design/bxds_pkg.sv
design/bxds_div.sv
design/bxds_ctrl.sv
design/bxds_dp.sv
design/box_area_downscaler.sv
design/bxds_checker.sv
tb/testbench.sv
